/* sv/spb_pkg.sv */
// Shared types and constants for the spectrum bar peak-hold block.
`default_nettype none
package spb_pkg;

	localparam int unsigned NUM_COLUMNS = 43;
	localparam int unsigned LEVEL_STEPS = 64;

	localparam int unsigned COL_W   = 6;
	localparam int unsigned LEVEL_W = 6;
	localparam int unsigned PIX_W   = 8;
	localparam int unsigned IDX_W   = $clog2(NUM_COLUMNS);
	localparam int unsigned PROD_W  = LEVEL_W + PIX_W;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [PIX_W-1:0] SCALE_MAX = 8'd254;
	localparam logic [PIX_W-1:0] FALL_MAX  = 8'd255;

	// request opcodes
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	// channel select codes
	localparam logic [1:0] MODE_LEFT  = 2'd0;
	localparam logic [1:0] MODE_RIGHT = 2'd1;
	localparam logic [1:0] MODE_MAX   = 2'd2;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BAR_HEIGHT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PEAKS_ENABLE = 2'd2;

	typedef struct packed {
		logic               op;
		logic [COL_W-1:0]   column;
		logic [LEVEL_W-1:0] level_left;
		logic [LEVEL_W-1:0] level_right;
	} spb_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] scaled_level;
		logic [PIX_W-1:0] bar_value;
		logic [PIX_W-1:0] previous_bar;
		logic [PIX_W-1:0] peak_value;
		logic [PIX_W-1:0] fall_step;
	} spb_out_t;

	// one stored column
	typedef struct packed {
		logic [PIX_W-1:0] bar;
		logic [PIX_W-1:0] prev;
		logic [PIX_W-1:0] peak;
		logic [PIX_W-1:0] fall;
	} spb_entry_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;    // update request taken, read column
		logic clear_all;  // clear request taken
		logic commit;     // write column back, load result
	} spb_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_update;  // in-range update request at the input
		logic is_clear;   // clear request at the input
	} spb_status_t;

endpackage
`default_nettype wire

/* sv/spb_ctrl.sv */
// Controller state machine for the spectrum bar peak-hold block.
`default_nettype none
module spb_ctrl
	import spb_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  wire         out_stall,
	input  spb_status_t st,
	output spb_cmd_t    cmd
);

	localparam logic S_IDLE   = 1'b0;
	localparam logic S_UPDATE = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic accept;
	logic slot_free;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd.capture   = accept && st.is_update;
		cmd.clear_all = accept && st.is_clear;
		cmd.commit    = (state_q == S_UPDATE) && slot_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.capture) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				if (cmd.commit) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_capture_to_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_UPDATE)
		else $error("capture did not move to update");

	a_commit_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (state_q == S_UPDATE) && (!out_valid_q || !out_stall))
		else $error("commit without a free result slot");

	a_commit_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("commit did not raise out_valid");

	a_no_capture_and_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.capture && cmd.clear_all) && !(cmd.commit && cmd.clear_all))
		else $error("clear overlaps an update");

endmodule
`default_nettype wire

/* sv/spb_dpath.sv */
// Datapath: config registers, column memory, valid bits and bar/peak update.
`default_nettype none
module spb_dpath
	import spb_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  spb_in_t              in_data,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [PIX_W-1:0]      cfg_data,
	input  spb_cmd_t             cmd,
	output spb_status_t          st,
	output spb_out_t             out_data
);

	// configuration
	logic [PIX_W-1:0] bar_height_q;
	logic [1:0]       channel_mode_q;
	logic             peaks_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_height_q   <= 8'd64;
			channel_mode_q <= MODE_LEFT;
			peaks_enable_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BAR_HEIGHT:   bar_height_q   <= cfg_data;
				CFG_CHANNEL_MODE: channel_mode_q <= cfg_data[1:0];
				CFG_PEAKS_ENABLE: peaks_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// request decode
	logic in_range;
	assign in_range     = ({2'b00, in_data.column} < 8'(NUM_COLUMNS));
	assign st.is_clear  = (in_data.op == OP_CLEAR);
	assign st.is_update = (in_data.op == OP_UPDATE) && in_range;

	// level select and scale, done on the input side
	logic [LEVEL_W-1:0] level;
	logic [PROD_W-1:0]  prod;
	logic [PROD_W-1:0]  quot;
	logic [PIX_W-1:0]   scaled;

	always_comb begin
		case (channel_mode_q)
			MODE_LEFT:  level = in_data.level_left;
			MODE_RIGHT: level = in_data.level_right;
			default: begin
				level = (in_data.level_left > in_data.level_right) ?
					in_data.level_left : in_data.level_right;
			end
		endcase
	end

	assign prod   = {{PIX_W{1'b0}}, level} * {{LEVEL_W{1'b0}}, bar_height_q};
	assign quot   = PROD_W'(prod / LEVEL_STEPS);
	assign scaled = (quot > {{LEVEL_W{1'b0}}, SCALE_MAX}) ? SCALE_MAX : quot[PIX_W-1:0];

	// column memory and valid bits
	logic [IDX_W-1:0]       rd_idx;
	spb_entry_t             mem [NUM_COLUMNS];
	logic [NUM_COLUMNS-1:0] col_valid_q;

	logic [IDX_W-1:0] idx_s1;
	logic [PIX_W-1:0] scaled_s1;
	spb_entry_t       rd_s1;
	logic             hit_s1;
	spb_entry_t       wr_entry;

	assign rd_idx = in_data.column[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_s1     <= mem[rd_idx];
			idx_s1    <= rd_idx;
			scaled_s1 <= scaled;
		end
		if (cmd.commit) begin
			mem[idx_s1] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_valid_q <= '0;
			hit_s1      <= 1'b0;
		end else begin
			if (cmd.capture) begin
				hit_s1 <= col_valid_q[rd_idx];
			end
			if (cmd.clear_all) begin
				col_valid_q <= '0;
			end else if (cmd.commit) begin
				col_valid_q[idx_s1] <= 1'b1;
			end
		end
	end

	// bar fall / rise and peak hold
	spb_entry_t       cur;
	logic [PIX_W-1:0] bar_n;
	logic [PIX_W-1:0] fall_n;
	logic [PIX_W-1:0] peak_n;
	logic [PIX_W:0]   bar_p1;

	always_comb begin
		cur    = hit_s1 ? rd_s1 : '0;
		bar_n  = cur.bar;
		fall_n = cur.fall;
		if (scaled_s1 < cur.bar) begin
			if (cur.bar >= cur.fall) begin
				bar_n = cur.bar - cur.fall;
				if (cur.fall != FALL_MAX) begin
					fall_n = cur.fall + 8'd1;
				end
			end else begin
				bar_n = '0;
			end
		end
		if (scaled_s1 > bar_n) begin
			bar_n  = scaled_s1;
			fall_n = 8'd1;
		end

		bar_p1 = {1'b0, bar_n} + 9'd1;
		peak_n = cur.peak;
		if (cur.peak <= scaled_s1) begin
			peak_n = scaled_s1 + 8'd1;
		end else if ((cur.peak != '0) && ({1'b0, cur.peak} > bar_p1)) begin
			peak_n = cur.peak - 8'd1;
		end

		wr_entry.bar  = bar_n;
		wr_entry.prev = cur.bar;
		wr_entry.peak = peak_n;
		wr_entry.fall = fall_n;
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_data.scaled_level <= scaled_s1;
			out_data.bar_value    <= bar_n;
			out_data.previous_bar <= cur.bar;
			out_data.peak_value   <= peaks_enable_q ? peak_n : '0;
			out_data.fall_step    <= fall_n;
		end
	end

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_all |=> col_valid_q == '0)
		else $error("clear left a column valid");

	a_commit_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> col_valid_q[$past(idx_s1)])
		else $error("committed column not marked valid");

	// a fresh column at level zero keeps a zero fall step, so only the bar is bounded
	a_bar_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (bar_n <= SCALE_MAX))
		else $error("bar out of range");

endmodule
`default_nettype wire

/* sv/spectrum_bar_peak_hold.sv */
// Top level of the spectrum bar peak-hold block.
//
// Input channel (in_valid / in_stall / in_data): one request per column
// update, or a clear request that forgets every column. A request is
// taken on a clock edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall / out_data): one result per
// in-range update request; clear requests and columns past the last one
// give no result.
// Config port (cfg_we / cfg_index / cfg_data): bar height, channel mode
// and peak enable, written while no request is in flight.
// Timing: an update request reads its column from the column memory on
// the accept edge and writes it back in the update state once the result
// slot is free, loading the result register at the same edge; out_valid
// is registered from that write-back. No new request is taken until the
// write-back, as in_stall stays high; a clear request does not hold it.
// Stall: the result holds while out_valid and out_stall are both high;
// a waiting update request then holds its write-back; in_stall stays high.
// Reset: clears all column valid bits (columns read as zero), empties
// the result register and restores bar height 64, left channel, peaks on.
`default_nettype none
module spectrum_bar_peak_hold
	import spb_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  spb_in_t              in_data,
	output logic                 out_valid,
	input  wire                  out_stall,
	output spb_out_t             out_data,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [PIX_W-1:0]      cfg_data
);

	spb_cmd_t    cmd;
	spb_status_t st;

	// sequencing: idle / update, plus result valid
	spb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// scaling, column memory, bar/peak math and result register
	spb_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
